/* hdl/command_line_tokenizer_macros.svh */
// ----------------------------------------------------------------------------
// command_line_tokenizer_macros.svh
// Assertion macros shared by the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define CLT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

/* hdl/clt_pkg.sv */
// ----------------------------------------------------------------------------
// clt_pkg
// Types and constants of the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

    // Field widths of the request and result channels
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 6;
    localparam int OFFSET_W = 5;
    localparam int COUNT_W  = 6;
    // Width that holds any counter value plus one at the widest parameters
    localparam int WIDE_W   = 9;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUOTE     = 2'd1;

    // Reset values of the configuration registers and the terminator byte
    localparam logic [BYTE_W-1:0] SEPARATOR_RESET = 8'd32;
    localparam logic [BYTE_W-1:0] QUOTE_RESET     = 8'd34;
    localparam logic [BYTE_W-1:0] TERMINATOR      = 8'd0;

    // Parse phases
    typedef enum logic [3:0] {
        PH_BEGIN        = 4'd0,
        PH_NAME         = 4'd1,
        PH_NAME_END     = 4'd2,
        PH_PARAM        = 4'd3,
        PH_PARAM_END    = 4'd4,
        PH_QUOTE_OPEN   = 4'd5,
        PH_IN_QUOTE     = 4'd6,
        PH_QUOTE_CLOSED = 4'd7,
        PH_DRAIN        = 4'd8
    } phase_t;

endpackage

/* hdl/clt_byte_if.sv */
// ----------------------------------------------------------------------------
// clt_byte_if
// Request channel carrying one command line byte.
// ----------------------------------------------------------------------------
interface clt_byte_if;
    import clt_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

/* hdl/clt_result_if.sv */
// ----------------------------------------------------------------------------
// clt_result_if
// Result channel carrying one tokenizer result per request.
// ----------------------------------------------------------------------------
interface clt_result_if;
    import clt_pkg::*;

    logic                valid;
    logic                ready;
    logic                char_valid;
    logic [BYTE_W-1:0]   char_out;
    logic [INDEX_W-1:0]  token_index;
    logic [OFFSET_W-1:0] char_offset;
    logic                token_end;
    logic                line_done;
    logic                parse_error;
    logic [COUNT_W-1:0]  param_count;

    modport source (
        output valid, output char_valid, output char_out, output token_index,
        output char_offset, output token_end, output line_done,
        output parse_error, output param_count, input ready
    );
    modport sink (
        input valid, input char_valid, input char_out, input token_index,
        input char_offset, input token_end, input line_done,
        input parse_error, input param_count, output ready
    );
endinterface

/* hdl/clt_cfg_if.sv */
// ----------------------------------------------------------------------------
// clt_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface clt_cfg_if;
    import clt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/command_line_tokenizer.sv */
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Result: registered at the edge that accepts its byte and offered on the
//   result channel from the next cycle on.
// Throughput: one byte per cycle; the result register decides the rate, and
//   a byte is taken whenever that register is empty or is read in the cycle.
// Reset: rst_n clears phase, counters and the result valid flag and restores
//   separator 32 and quote 34. No clearing pass is needed.
// ----------------------------------------------------------------------------
module command_line_tokenizer #(
    parameter int MAX_PARAMS    = 32,
    parameter int MAX_TOKEN_LEN = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    clt_byte_if.sink     line,
    clt_result_if.source result,
    clt_cfg_if.sink      cfg
);
    import clt_pkg::*;

    `include "command_line_tokenizer_macros.svh"

    localparam int PW = $clog2(MAX_PARAMS + 1);
    localparam int OW = $clog2(MAX_TOKEN_LEN);
    localparam logic [PW-1:0] PARAMS_LIMIT = PW'(MAX_PARAMS);
    localparam logic [OW-1:0] OFFSET_LIMIT = OW'(MAX_TOKEN_LEN - 1);

    // Actions decoded for one byte
    typedef struct packed {
        logic   store;      // emit a token character
        logic   param_tok;  // character or end belongs to a parameter
        logic   err;        // format error on this byte
        logic   err_nul;    // the error byte is the terminator
        logic   tok_end;    // current token ends on this byte
        logic   fin;        // a parameter completes on this byte
        logic   line_end;   // line ends normally on this byte
        logic   clear;      // terminator that ends dropping
        phase_t phase_go;   // phase taken when there is no error and no line end
    } act_t;

    logic [BYTE_W-1:0] separator_reg;
    logic [BYTE_W-1:0] quote_reg;
    phase_t            phase_reg, phase_next;
    logic [PW-1:0]     params_reg, params_next;
    logic [OW-1:0]     offset_reg, offset_next;

    logic                out_valid_reg;
    logic                char_valid_reg, char_valid_next;
    logic [BYTE_W-1:0]   char_out_reg, char_out_next;
    logic [INDEX_W-1:0]  token_index_reg, token_index_next;
    logic [OFFSET_W-1:0] char_offset_reg, char_offset_next;
    logic                token_end_reg, token_end_next;
    logic                line_done_reg, line_done_next;
    logic                parse_error_reg, parse_error_next;
    logic [COUNT_W-1:0]  param_count_reg, param_count_next;

    logic          accept;
    logic          is_nul, is_sep, is_quo, is_ord;
    logic          tok_full, params_full;
    logic [WIDE_W-1:0] param_idx_wide;
    act_t          act;

    // Take a byte when the result register is free or drains this cycle
    assign line.ready = !out_valid_reg || result.ready;
    assign accept     = line.valid && line.ready;
    assign cfg.ready  = 1'b1;

    // Classify the byte; separator wins over quote
    assign is_nul = (line.in_byte == TERMINATOR);
    assign is_sep = !is_nul && (line.in_byte == separator_reg);
    assign is_quo = !is_nul && !is_sep && (line.in_byte == quote_reg);
    assign is_ord = !is_nul && !is_sep && !is_quo;

    assign tok_full       = (offset_reg >= OFFSET_LIMIT);
    assign params_full    = (params_reg == PARAMS_LIMIT);
    assign param_idx_wide = WIDE_W'(params_reg) + WIDE_W'(1);

    // Decode the actions for the current phase and byte class
    always_comb
    begin
        act          = '0;
        act.phase_go = phase_reg;
        case (phase_reg)
            PH_BEGIN:
            begin
                if (is_quo || is_nul)
                begin
                    act.err     = 1'b1;
                    act.err_nul = is_nul;
                end
                else if (is_ord)
                begin
                    act.store    = 1'b1;
                    act.phase_go = PH_NAME;
                end
            end
            PH_NAME:
            begin
                if (is_sep)
                begin
                    act.tok_end  = 1'b1;
                    act.phase_go = PH_NAME_END;
                end
                else if (is_quo)
                    act.err = 1'b1;
                else if (is_nul)
                begin
                    act.tok_end  = 1'b1;
                    act.line_end = 1'b1;
                end
                else
                    act.store = 1'b1;
            end
            PH_NAME_END, PH_PARAM_END:
            begin
                if (is_nul)
                    act.line_end = 1'b1;
                else if (is_quo || is_ord)
                begin
                    if (params_full)
                        act.err = 1'b1;
                    else if (is_quo)
                        act.phase_go = PH_QUOTE_OPEN;
                    else
                    begin
                        act.store     = 1'b1;
                        act.param_tok = 1'b1;
                        act.phase_go  = PH_PARAM;
                    end
                end
            end
            PH_PARAM:
            begin
                if (is_sep || is_nul)
                begin
                    act.tok_end   = 1'b1;
                    act.param_tok = 1'b1;
                    act.fin       = 1'b1;
                    act.line_end  = is_nul;
                    act.phase_go  = PH_PARAM_END;
                end
                else if (is_quo)
                    act.err = 1'b1;
                else
                begin
                    act.store     = 1'b1;
                    act.param_tok = 1'b1;
                end
            end
            PH_QUOTE_OPEN:
            begin
                if (is_quo || is_nul)
                begin
                    act.err     = 1'b1;
                    act.err_nul = is_nul;
                end
                else
                begin
                    act.store     = 1'b1;
                    act.param_tok = 1'b1;
                    act.phase_go  = PH_IN_QUOTE;
                end
            end
            PH_IN_QUOTE:
            begin
                if (is_quo)
                    act.phase_go = PH_QUOTE_CLOSED;
                else if (is_nul)
                begin
                    act.err     = 1'b1;
                    act.err_nul = 1'b1;
                end
                else
                begin
                    act.store     = 1'b1;
                    act.param_tok = 1'b1;
                end
            end
            PH_QUOTE_CLOSED:
            begin
                if (is_sep || is_nul)
                begin
                    act.tok_end   = 1'b1;
                    act.param_tok = 1'b1;
                    act.fin       = 1'b1;
                    act.line_end  = is_nul;
                    act.phase_go  = PH_PARAM_END;
                end
                else
                    act.err = 1'b1;
            end
            default:
            begin
                if (is_nul)
                begin
                    act.clear    = 1'b1;
                    act.phase_go = PH_BEGIN;
                end
            end
        endcase

        // Turn a store into an error when the token is full
        if (act.store && tok_full)
        begin
            act.store = 1'b0;
            act.err   = 1'b1;
        end
    end

    // Next phase and counters
    always_comb
    begin
        if (act.err)
            phase_next = act.err_nul ? PH_BEGIN : PH_DRAIN;
        else if (act.line_end)
            phase_next = PH_BEGIN;
        else
            phase_next = act.phase_go;

        if (act.err || act.line_end || act.clear)
            params_next = '0;
        else if (act.fin)
            params_next = params_reg + PW'(1);
        else
            params_next = params_reg;

        if (act.store)
            offset_next = offset_reg + OW'(1);
        else if (act.err || act.line_end || act.clear || act.tok_end)
            offset_next = '0;
        else
            offset_next = offset_reg;
    end

    // Result fields for the byte
    always_comb
    begin
        char_valid_next  = act.store;
        char_out_next    = act.store ? line.in_byte : '0;
        char_offset_next = act.store ? OFFSET_W'(offset_reg) : '0;
        token_end_next   = act.tok_end;
        line_done_next   = act.line_end;
        parse_error_next = act.err;
        if ((act.store || act.tok_end) && act.param_tok)
            token_index_next = param_idx_wide[INDEX_W-1:0];
        else
            token_index_next = '0;
        if (act.err)
            param_count_next = COUNT_W'(params_reg);
        else if (act.line_end && act.fin)
            param_count_next = param_idx_wide[COUNT_W-1:0];
        else if (act.line_end)
            param_count_next = COUNT_W'(params_reg);
        else
            param_count_next = COUNT_W'(params_next);
    end

    // Hold parse state; advance on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_BEGIN;
            params_reg <= '0;
            offset_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            params_reg <= params_next;
            offset_reg <= offset_next;
        end
    end

    // Write configuration registers; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            separator_reg <= SEPARATOR_RESET;
            quote_reg     <= QUOTE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_SEPARATOR: separator_reg <= cfg.data;
                REG_QUOTE:     quote_reg     <= cfg.data;
                default:       ;
            endcase
        end
    end

    // Track result register occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Load result payload on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_valid_reg  <= char_valid_next;
            char_out_reg    <= char_out_next;
            token_index_reg <= token_index_next;
            char_offset_reg <= char_offset_next;
            token_end_reg   <= token_end_next;
            line_done_reg   <= line_done_next;
            parse_error_reg <= parse_error_next;
            param_count_reg <= param_count_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.char_valid  = char_valid_reg;
    assign result.char_out    = char_out_reg;
    assign result.token_index = token_index_reg;
    assign result.char_offset = char_offset_reg;
    assign result.token_end   = token_end_reg;
    assign result.line_done   = line_done_reg;
    assign result.parse_error = parse_error_reg;
    assign result.param_count = param_count_reg;

    // Checks on the tokenizer's own state
    `CLT_NEVER(a_err_and_done,
        out_valid_reg && parse_error_reg && line_done_reg,
        "error with line done")
    `CLT_NEVER(a_char_with_end,
        out_valid_reg && char_valid_reg && (token_end_reg || parse_error_reg),
        "char with end or error")
    `CLT_ASSERT(a_offset_bound, offset_reg <= OFFSET_LIMIT, "token offset past limit")
    `CLT_ASSERT(a_params_bound, params_reg <= PARAMS_LIMIT, "parameter count past limit")
    `CLT_ASSERT(a_err_drains,
        (accept && act.err && !act.err_nul) |=>
            (phase_reg == PH_DRAIN && params_reg == '0 && offset_reg == '0),
        "error did not enter drain")

endmodule
